/* design/log2_histogram_stats_accumulator_defines.svh */
// Assertion macros shared by the checker of the statistics accumulator.
// All properties sample on the rising edge of clk and are switched off
// while rst_n is low.
`ifndef LOG2_HISTOGRAM_STATS_ACCUMULATOR_DEFINES_SVH
`define LOG2_HISTOGRAM_STATS_ACCUMULATOR_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LHS_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("accumulator check failed");

// The consequent must hold in the cycle after the antecedent.
`define LHS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("accumulator check failed");

`endif

/* design/lhs_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package lhs_pkg;

    // Fixed field widths of the item and result ports.
    localparam int SAMPLE_W  = 32;
    localparam int WIDE_W    = 64;
    localparam int BIN_IDX_W = 5;
    // Wide enough for a bit length of up to 32 and a bin number of up to 32.
    localparam int BIN_SEL_W = 6;

    // Sample after the square and bin stage, handed to the update logic.
    typedef struct packed {
        logic [SAMPLE_W-1:0]  sample;
        logic [WIDE_W-1:0]    square;
        logic [BIN_SEL_W-1:0] bin;
    } prep_item_t;

endpackage

`default_nettype wire

/* design/lhs_prep.sv */
`timescale 1ns / 1ps
`default_nettype none

module lhs_prep #(
    parameter int SAMPLE_BITS = 32,
    parameter int NUM_BINS    = 20
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic [lhs_pkg::SAMPLE_W-1:0]  sample,
    input  wire logic                          sample_valid,
    output logic                               sample_stall,
    input  wire logic                          load,
    output logic                               item_valid,
    output lhs_pkg::prep_item_t                item
);
    import lhs_pkg::*;

    localparam logic [SAMPLE_W-1:0] SAMPLE_MASK =
        SAMPLE_W'((64'd1 << SAMPLE_BITS) - 64'd1);
    localparam logic [BIN_SEL_W-1:0] LAST_BIN = BIN_SEL_W'(NUM_BINS - 1);

    logic                 s1_valid_reg;
    logic                 s1_valid_next;
    logic [SAMPLE_W-1:0]  s1_sample_reg;
    logic                 s2_valid_reg;
    logic                 s2_valid_next;
    prep_item_t           s2_item_reg;
    prep_item_t           s2_item_next;
    logic                 s1_en;
    logic                 s2_en;
    logic [BIN_SEL_W-1:0] bit_len;

    // A stage moves on when it is empty or when the stage after it takes its item.
    assign s2_en        = !s2_valid_reg || load;
    assign s1_en        = !s1_valid_reg || s2_en;
    assign sample_stall = !s1_en;

    assign s1_valid_next = s1_en ? sample_valid : s1_valid_reg;
    assign s2_valid_next = s2_en ? s1_valid_reg : s2_valid_reg;

    // Bit length of the sample: position of the highest set bit plus one.
    always_comb
    begin
        bit_len = '0;
        for (int i = 0; i < SAMPLE_W; i++)
        begin
            if (s1_sample_reg[i])
            begin
                bit_len = BIN_SEL_W'(i + 1);
            end
        end
    end

    always_comb
    begin
        s2_item_next.sample = s1_sample_reg;
        s2_item_next.square = WIDE_W'(s1_sample_reg) * WIDE_W'(s1_sample_reg);
        s2_item_next.bin    = (bit_len >= LAST_BIN) ? LAST_BIN : bit_len;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_en)
        begin
            s1_sample_reg <= sample & SAMPLE_MASK;
        end
        if (s2_en)
        begin
            s2_item_reg <= s2_item_next;
        end
    end

    assign item_valid = s2_valid_reg;
    assign item       = s2_item_reg;

endmodule

`default_nettype wire

/* design/lhs_stats.sv */
`timescale 1ns / 1ps
`default_nettype none

module lhs_stats (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          load,
    input  wire lhs_pkg::prep_item_t           item,
    output logic [lhs_pkg::WIDE_W-1:0]         sample_count,
    output logic [lhs_pkg::WIDE_W-1:0]         running_sum,
    output logic [lhs_pkg::WIDE_W-1:0]         running_sum_sq,
    output logic [lhs_pkg::SAMPLE_W-1:0]       smallest,
    output logic [lhs_pkg::SAMPLE_W-1:0]       largest
);
    import lhs_pkg::*;

    logic [WIDE_W-1:0]   count_reg;
    logic [WIDE_W-1:0]   count_next;
    logic [WIDE_W-1:0]   sum_reg;
    logic [WIDE_W-1:0]   sum_next;
    logic [WIDE_W-1:0]   sum_sq_reg;
    logic [WIDE_W-1:0]   sum_sq_next;
    logic [SAMPLE_W-1:0] min_reg;
    logic [SAMPLE_W-1:0] min_next;
    logic [SAMPLE_W-1:0] max_reg;
    logic [SAMPLE_W-1:0] max_next;
    logic [SAMPLE_W-1:0] min_base;
    logic [SAMPLE_W-1:0] max_base;
    logic                first;

    // A count of zero (after reset or after a wrap) reloads both extremes.
    assign first    = (count_reg == '0);
    assign min_base = first ? item.sample : min_reg;
    assign max_base = first ? item.sample : max_reg;

    assign count_next  = count_reg + WIDE_W'(1);
    assign sum_next    = sum_reg + WIDE_W'(item.sample);
    assign sum_sq_next = sum_sq_reg + item.square;
    assign min_next    = (item.sample < min_base) ? item.sample : min_base;
    assign max_next    = (item.sample > max_base) ? item.sample : max_base;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            sum_reg    <= '0;
            sum_sq_reg <= '0;
            min_reg    <= '0;
            max_reg    <= '0;
        end
        else if (load)
        begin
            count_reg  <= count_next;
            sum_reg    <= sum_next;
            sum_sq_reg <= sum_sq_next;
            min_reg    <= min_next;
            max_reg    <= max_next;
        end
    end

    assign sample_count   = count_reg;
    assign running_sum    = sum_reg;
    assign running_sum_sq = sum_sq_reg;
    assign smallest       = min_reg;
    assign largest        = max_reg;

endmodule

`default_nettype wire

/* design/lhs_hist.sv */
`timescale 1ns / 1ps
`default_nettype none

module lhs_hist #(
    parameter int NUM_BINS = 20
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          load,
    input  wire lhs_pkg::prep_item_t           item,
    output logic [lhs_pkg::BIN_IDX_W-1:0]      bin_index,
    output logic [lhs_pkg::SAMPLE_W-1:0]       bin_total
);
    import lhs_pkg::*;

    localparam int SEL_W = $clog2(NUM_BINS);

    logic [SAMPLE_W-1:0]  bin_cnt_reg [NUM_BINS];
    logic [SAMPLE_W-1:0]  cnt_now;
    logic [SAMPLE_W-1:0]  cnt_next;
    logic [SEL_W-1:0]     sel;
    logic [BIN_IDX_W-1:0] bin_index_reg;
    logic [SAMPLE_W-1:0]  bin_total_reg;

    assign sel      = item.bin[SEL_W-1:0];
    assign cnt_now  = bin_cnt_reg[sel];
    // Counters stop at all ones.
    assign cnt_next = (cnt_now == '1) ? cnt_now : cnt_now + SAMPLE_W'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_BINS; i++)
            begin
                bin_cnt_reg[i] <= '0;
            end
        end
        else if (load)
        begin
            bin_cnt_reg[sel] <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            bin_index_reg <= item.bin[BIN_IDX_W-1:0];
            bin_total_reg <= cnt_next;
        end
    end

    assign bin_index = bin_index_reg;
    assign bin_total = bin_total_reg;

endmodule

`default_nettype wire

/* design/log2_histogram_stats_accumulator.sv */
`timescale 1ns / 1ps
`default_nettype none

// Channel  | Direction | Handshake                   | Payload
// ---------+-----------+-----------------------------+------------------------------------
// sample   | in        | sample_valid / sample_stall | sample
// result   | out       | result_valid / result_stall | sample_count, running_sum,
//          |           |                             | running_sum_sq, smallest, largest,
//          |           |                             | bin_index, bin_total
//
// One item is taken every cycle while sample_stall is low. Its result passes
// through the input register, the square and bin register and the result
// register before it is presented.
// The 32 by 32 bit squarer and the bit-length logic sit between the first two
// registers; the adds and compares sit between the last two.
// rst_n clears the statistics, every histogram bin and all valid flags at once.
// A stall on the result side holds the result and backs up the pipeline one
// stage at a time; empty stages keep taking items until all three are full.

module log2_histogram_stats_accumulator #(
    parameter int NUM_BINS    = 20,
    parameter int SAMPLE_BITS = 32
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic [lhs_pkg::SAMPLE_W-1:0]  sample,
    input  wire logic                          sample_valid,
    output logic                               sample_stall,
    output logic                               result_valid,
    input  wire logic                          result_stall,
    output logic [lhs_pkg::WIDE_W-1:0]         sample_count,
    output logic [lhs_pkg::WIDE_W-1:0]         running_sum,
    output logic [lhs_pkg::WIDE_W-1:0]         running_sum_sq,
    output logic [lhs_pkg::SAMPLE_W-1:0]       smallest,
    output logic [lhs_pkg::SAMPLE_W-1:0]       largest,
    output logic [lhs_pkg::BIN_IDX_W-1:0]      bin_index,
    output logic [lhs_pkg::SAMPLE_W-1:0]       bin_total
);
    import lhs_pkg::*;

    logic       item_valid;
    prep_item_t item;
    logic       load;
    logic       result_valid_reg;
    logic       result_valid_next;

    // The front end masks the sample, then forms its square and its bin.
    lhs_prep #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .NUM_BINS    (NUM_BINS)
    ) u_prep (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample       (sample),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .load         (load),
        .item_valid   (item_valid),
        .item         (item)
    );

    // A prepared item is folded into the state whenever the result register
    // is empty or its present contents are being taken this cycle. The
    // statistics registers are themselves the result payload, so a stalled
    // result stays put without any extra copy.
    assign load = item_valid && (!result_valid_reg || !result_stall);

    always_comb
    begin
        if (load)
        begin
            result_valid_next = 1'b1;
        end
        else if (!result_stall)
        begin
            result_valid_next = 1'b0;
        end
        else
        begin
            result_valid_next = result_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else
        begin
            result_valid_reg <= result_valid_next;
        end
    end

    assign result_valid = result_valid_reg;

    // Count, sums of values and squares, and the running extremes.
    lhs_stats u_stats (
        .clk            (clk),
        .rst_n          (rst_n),
        .load           (load),
        .item           (item),
        .sample_count   (sample_count),
        .running_sum    (running_sum),
        .running_sum_sq (running_sum_sq),
        .smallest       (smallest),
        .largest        (largest)
    );

    // Log2 histogram with saturating bin counters.
    lhs_hist #(
        .NUM_BINS (NUM_BINS)
    ) u_hist (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (load),
        .item      (item),
        .bin_index (bin_index),
        .bin_total (bin_total)
    );

endmodule

`default_nettype wire

/* design/lhs_checker.sv */
`timescale 1ns / 1ps
`default_nettype none

`include "log2_histogram_stats_accumulator_defines.svh"

module lhs_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        result_valid,
    input wire logic        result_stall,
    input wire logic [63:0] sample_count,
    input wire logic [31:0] smallest,
    input wire logic [31:0] largest,
    input wire logic [4:0]  bin_index,
    input wire logic [31:0] bin_total
);

    // A held result keeps its count.
    `LHS_ASSERT_NEXT(a_held_result, result_valid && result_stall, result_valid && $stable(sample_count))

    // Results that follow one another differ in count by exactly one.
    `LHS_ASSERT_SAME(a_count_step, (result_valid && !result_stall) ##1 result_valid, sample_count == $past(sample_count) + 64'd1)

    // Extremes are ordered and the bin just hit is never empty.
    `LHS_ASSERT_SAME(a_result_sane, result_valid, smallest <= largest && bin_total != 32'd0)

    // A sample in bin zero is zero, so the smallest sample is zero too.
    `LHS_ASSERT_SAME(a_zero_bin, result_valid && bin_index == 5'd0, smallest == 32'd0)

endmodule

bind log2_histogram_stats_accumulator lhs_checker u_lhs_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .sample_count (sample_count),
    .smallest     (smallest),
    .largest      (largest),
    .bin_index    (bin_index),
    .bin_total    (bin_total)
);

`default_nettype wire

/* tb/tb.sv */
`timescale 1ns / 1ps

module tb;

    import lhs_pkg::*;

    // The block is built with its default shape: twenty log2 bins and full
    // width samples.
    localparam int NUM_BINS    = 20;
    localparam int SAMPLE_BITS = 32;
    localparam logic [SAMPLE_W-1:0] SAMPLE_MASK = {SAMPLE_W{1'b1}} >> (SAMPLE_W - SAMPLE_BITS);

    // Number of random samples after the directed corner values.
    localparam int RANDOM_SAMPLES = 630;
    // The last stretch of the run is driven with no idling on either side.
    localparam int QUIET_TAIL     = 80;
    // Cycles without a handshake on either channel before the run is abandoned.
    // The slowest correct item waits out a sender gap, a receiver stall and
    // three pipeline stages, so this leaves a wide margin.
    localparam int WATCHDOG_LIMIT = 1000;
    // Drain time after the last expected result.
    localparam int DRAIN_CYCLES   = 12;

    // One expected result item.
    typedef struct {
        logic [WIDE_W-1:0]    count;
        logic [WIDE_W-1:0]    sum;
        logic [WIDE_W-1:0]    sum_sq;
        logic [SAMPLE_W-1:0]  smallest;
        logic [SAMPLE_W-1:0]  largest;
        logic [BIN_IDX_W-1:0] bin;
        logic [SAMPLE_W-1:0]  bin_count;
    } stats_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic [SAMPLE_W-1:0]  sample       = '0;
    logic                 sample_valid = 1'b0;
    logic                 sample_stall;
    logic                 result_valid;
    logic                 result_stall = 1'b0;
    logic [WIDE_W-1:0]    sample_count;
    logic [WIDE_W-1:0]    running_sum;
    logic [WIDE_W-1:0]    running_sum_sq;
    logic [SAMPLE_W-1:0]  smallest;
    logic [SAMPLE_W-1:0]  largest;
    logic [BIN_IDX_W-1:0] bin_index;
    logic [SAMPLE_W-1:0]  bin_total;

    // Samples waiting to be driven, and the statistics that the samples
    // already taken by the block should produce, oldest first.
    logic [SAMPLE_W-1:0] pending_samples[$];
    stats_t              expected_stats[$];

    // The testbench's own copy of the accumulator state.
    logic [WIDE_W-1:0]   model_count;
    logic [WIDE_W-1:0]   model_sum;
    logic [WIDE_W-1:0]   model_sum_sq;
    logic [SAMPLE_W-1:0] model_min;
    logic [SAMPLE_W-1:0] model_max;
    logic [SAMPLE_W-1:0] model_bins[NUM_BINS];

    int total_samples = 0;
    int samples_taken = 0;
    int results_seen  = 0;
    int mismatches    = 0;
    int gap_left      = 0;
    int stall_left    = 0;
    int quiet_cycles  = 0;

    log2_histogram_stats_accumulator #(
        .NUM_BINS    (NUM_BINS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .sample         (sample),
        .sample_valid   (sample_valid),
        .sample_stall   (sample_stall),
        .result_valid   (result_valid),
        .result_stall   (result_stall),
        .sample_count   (sample_count),
        .running_sum    (running_sum),
        .running_sum_sq (running_sum_sq),
        .smallest       (smallest),
        .largest        (largest),
        .bin_index      (bin_index),
        .bin_total      (bin_total)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Every mismatch goes through here: one line each, and a running count.
    task automatic flag_mismatch(input string what);
        $display("[%0t] mismatch on result %0d: %0s", $realtime, results_seen, what);
        mismatches++;
    endtask

    // Appends one sample to the queue of items still to be driven.
    task automatic queue_sample(input logic [SAMPLE_W-1:0] value);
        pending_samples.insert(pending_samples.size(), value);
    endtask

    // Folds one accepted sample into the state copy and queues the result
    // item that the block should return for it. The first sample after reset
    // loads both the smallest and the largest value. The bin is the bit length
    // of the sample, clamped to the last bin, and bin counters stick at their
    // maximum instead of wrapping.
    task automatic accumulate_sample(input logic [SAMPLE_W-1:0] raw);
        logic [SAMPLE_W-1:0] value;
        logic [WIDE_W-1:0]   wide;
        int                  bit_len;
        stats_t              stats;

        value = raw & SAMPLE_MASK;
        wide  = {{(WIDE_W - SAMPLE_W){1'b0}}, value};
        if (model_count == '0)
        begin
            model_min = value;
            model_max = value;
        end
        model_count  = model_count + 64'd1;
        model_sum    = model_sum + wide;
        model_sum_sq = model_sum_sq + wide * wide;
        if (value < model_min)
            model_min = value;
        if (value > model_max)
            model_max = value;

        bit_len = 0;
        for (int b = 0; b < SAMPLE_W; b++)
        begin
            if (value[b])
                bit_len = b + 1;
        end
        if (bit_len >= NUM_BINS)
            bit_len = NUM_BINS - 1;
        if (model_bins[bit_len] != {SAMPLE_W{1'b1}})
            model_bins[bit_len] = model_bins[bit_len] + 32'd1;

        stats.count     = model_count;
        stats.sum       = model_sum;
        stats.sum_sq    = model_sum_sq;
        stats.smallest  = model_min;
        stats.largest   = model_max;
        stats.bin       = bit_len[BIN_IDX_W-1:0];
        stats.bin_count = model_bins[bit_len];
        expected_stats.insert(expected_stats.size(), stats);
    endtask

    // Idling is switched off for a stretch in the middle of the run and for
    // the whole of its tail, so that back-to-back items are seen as well.
    function automatic bit idling_allowed(input int progress);
        return progress < total_samples - QUIET_TAIL && !(progress >= 300 && progress < 360);
    endfunction

    // One random sample. Most are drawn by picking a bit length first, so that
    // every histogram bin, including the clamped last one, is well populated;
    // the rest are uniform over all 32 bits or sit on the extremes.
    function automatic logic [SAMPLE_W-1:0] random_sample();
        int          pick;
        int          bit_len;
        logic [63:0] top;

        pick = $urandom_range(0, 9);
        if (pick < 6)
        begin
            bit_len = $urandom_range(0, SAMPLE_W);
            if (bit_len == 0)
                return '0;
            top = 64'd1 << (bit_len - 1);
            return SAMPLE_W'(top | ({32'd0, $urandom} & (top - 1)));
        end
        else if (pick < 9)
        begin
            return $urandom;
        end
        else
        begin
            case ($urandom_range(0, 3))
                0:       return '0;
                1:       return 1;
                2:       return {SAMPLE_W{1'b1}};
                default: return {SAMPLE_W{1'b1}} - $urandom_range(1, 16);
            endcase
        end
    endfunction

    // Sample driver. A sample that has been presented stays on the port until
    // the block takes it; idle gaps of random length are put in between items,
    // never in the middle of a handshake. The state copy is updated
    // at the very edge where the item is taken, from the values on the ports
    // before that edge.
    always @(posedge clk or negedge rst_n)
    begin : sample_driver
        bit taken;

        if (!rst_n)
        begin
            sample_valid <= 1'b0;
            sample       <= '0;
            gap_left     <= 0;
        end
        else
        begin
            taken = sample_valid && !sample_stall;
            if (taken)
            begin
                accumulate_sample(sample);
                samples_taken++;
            end

            if (sample_valid && !taken)
            begin
                // Held: the same item stays on the port.
            end
            else if (gap_left != 0)
            begin
                gap_left     <= gap_left - 1;
                sample_valid <= 1'b0;
            end
            else if (pending_samples.size() != 0 && idling_allowed(samples_taken)
                     && $urandom_range(0, 5) == 0)
            begin
                gap_left     <= $urandom_range(0, 8);
                sample_valid <= 1'b0;
            end
            else if (pending_samples.size() != 0)
            begin
                sample       <= pending_samples.pop_front();
                sample_valid <= 1'b1;
            end
            else
            begin
                sample_valid <= 1'b0;
            end
        end
    end

    // Result monitor. Each result item taken from the block is compared field
    // by field with the oldest expectation. The stall line is raised in random
    // bursts, which backs the pipeline up stage by stage.
    always @(posedge clk or negedge rst_n)
    begin : result_monitor
        stats_t want;

        if (!rst_n)
        begin
            result_stall <= 1'b0;
            stall_left   <= 0;
        end
        else
        begin
            if (result_valid && !result_stall)
            begin
                results_seen++;
                if (expected_stats.size() == 0)
                begin
                    flag_mismatch("result item arrived with no sample outstanding");
                end
                else
                begin
                    want = expected_stats.pop_front();
                    if (sample_count !== want.count)
                        flag_mismatch($sformatf("sample_count %h, expected %h",
                                                sample_count, want.count));
                    if (running_sum !== want.sum)
                        flag_mismatch($sformatf("running_sum %h, expected %h",
                                                running_sum, want.sum));
                    if (running_sum_sq !== want.sum_sq)
                        flag_mismatch($sformatf("running_sum_sq %h, expected %h",
                                                running_sum_sq, want.sum_sq));
                    if (smallest !== want.smallest)
                        flag_mismatch($sformatf("smallest %h, expected %h",
                                                smallest, want.smallest));
                    if (largest !== want.largest)
                        flag_mismatch($sformatf("largest %h, expected %h",
                                                largest, want.largest));
                    if (bin_index !== want.bin)
                        flag_mismatch($sformatf("bin_index %0d, expected %0d",
                                                bin_index, want.bin));
                    if (bin_total !== want.bin_count)
                        flag_mismatch($sformatf("bin_total %0d, expected %0d",
                                                bin_total, want.bin_count));
                end
            end

            if (stall_left != 0)
            begin
                stall_left   <= stall_left - 1;
                result_stall <= 1'b1;
            end
            else if (idling_allowed(results_seen) && $urandom_range(0, 5) == 0)
            begin
                stall_left   <= $urandom_range(0, 8);
                result_stall <= 1'b1;
            end
            else
            begin
                result_stall <= 1'b0;
            end
        end
    end

    // Watchdog: a long run of cycles with no handshake on either channel means
    // the block has hung or lost an item.
    always @(posedge clk)
    begin
        if (!rst_n || (sample_valid && !sample_stall) || (result_valid && !result_stall))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles == WATCHDOG_LIMIT)
        begin
            $display("watchdog: no handshake for %0d cycles, %0d of %0d results seen",
                     WATCHDOG_LIMIT, results_seen, total_samples);
            $display("RESULT: ERROR");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin : run_control
        int bins_hit;

        model_count  = '0;
        model_sum    = '0;
        model_sum_sq = '0;
        model_min    = '0;
        model_max    = '0;
        foreach (model_bins[i])
            model_bins[i] = '0;

        // Directed corner values. The first sample is a middle value, so that
        // loading the smallest and largest value from the first sample shows
        // (a smallest of zero would otherwise survive from reset). Later come
        // zero, one, the full scale value, the edges of the last unclamped bin
        // and of the clamped range, the top bit alone and alternating bits.
        queue_sample(32'd1000);
        queue_sample(32'd5);
        queue_sample(32'd0);
        queue_sample(32'd1);
        queue_sample(32'hFFFF_FFFF);
        queue_sample(32'd2);
        queue_sample(32'd3);
        queue_sample(32'h0003_FFFF);
        queue_sample(32'h0004_0000);
        queue_sample(32'h0007_FFFF);
        queue_sample(32'h0008_0000);
        queue_sample(32'h7FFF_FFFF);
        queue_sample(32'h8000_0000);
        queue_sample(32'hAAAA_AAAA);
        queue_sample(32'h5555_5555);
        queue_sample(32'h0000_FFFF);
        queue_sample(32'h0001_0000);
        queue_sample(32'hFFFF_FFFF);
        queue_sample(32'd0);
        queue_sample(32'hFFFF_FFFE);
        for (int n = 0; n < RANDOM_SAMPLES; n++)
            queue_sample(random_sample());
        total_samples = pending_samples.size();

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        while (samples_taken != total_samples)
            @(posedge clk);
        while (expected_stats.size() != 0)
            @(posedge clk);
        // Let any stray extra result item come out before the verdict.
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (expected_stats.size() != 0)
            flag_mismatch($sformatf("%0d expected result items never arrived",
                                    expected_stats.size()));

        bins_hit = 0;
        foreach (model_bins[i])
        begin
            if (model_bins[i] != 0)
                bins_hit++;
        end
        $display("Summary: %0d samples sent (20 corner values, the rest random over all bit lengths),",
                 total_samples);
        $display("         %0d results checked, %0d of %0d bins filled, %0d mismatches.",
                 results_seen, bins_hit, NUM_BINS, mismatches);
        if (mismatches == 0)
        begin
            $display("RESULT: OK");
        end
        else
        begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
